FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the base64 stream decoder RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define B64SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the consequent holds whenever the antecedent holds.
`define B64SD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define B64SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define B64SD_ASSERT(lbl, prop, msg)
`define B64SD_ASSERT_IMP(lbl, ante, cons, msg)
`define B64SD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/b64sd_pkg.sv
// ---------------------------------------------------------------------------
// Base64 stream decoder package
// Payload types, character constants and the alphabet lookup function.
// ---------------------------------------------------------------------------
package b64sd_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned ShownWidth    = 16;

  // Characters with a special meaning in the stream.
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Position of a character within its group of four.
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_FOURTH = 2'd3;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic                  byte_valid;
    logic [7:0]            data_byte;
    logic                  done_res;
    logic [ShownWidth-1:0] decoded_count;
  } out_item_t;

  // Maps one character to its 6-bit value; anything outside the alphabet is zero.
  function automatic logic [5:0] sextet(input logic [7:0] ch);
    logic [5:0] v;
    v = '0;
    if (ch inside {[8'h41:8'h5A]}) begin
      v = 6'(ch - 8'h41);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      v = 6'(ch - 8'h61 + 8'd26);
    end else if (ch inside {[8'h30:8'h39]}) begin
      v = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == CH_PLUS) begin
      v = 6'd62;
    end else if (ch == CH_SLASH) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

FILE: hdl/base64_stream_decoder_top.sv
// Each result is written into a registered result queue when its character is transferred.
// One character per cycle while the input does not stall; a character that ends the string
// adds a count result, so the output side then has two results to take for it.
// The four-entry result queue sets the stall: input stalls while more than two results wait.
// Reset (rst_ni low, asynchronous) clears the decoder state and empties the queue.
// ---------------------------------------------------------------------------
// Base64 stream decoder top level
// Decodes one base64 character per transfer into bytes and reports the
// byte count of each string on its last character.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_stream_decoder_top #(
  parameter int unsigned COUNT_WIDTH = b64sd_pkg::CountWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  b64sd_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b64sd_pkg::out_item_t out_data_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // -------------------------------------------------------------------------
  // Decoder state. It is updated in the same cycle a character is
  // transferred, so the next character sees it at once.
  // -------------------------------------------------------------------------
  logic [1:0]             phase_q, phase_d;
  logic [5:0]             pend_q, pend_d;
  logic                   stopped_q, stopped_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;

  logic in_acc;
  logic out_acc;

  // Decode of the incoming character.
  logic [7:0]             ch;
  logic                   last;
  logic [5:0]             val;
  logic                   is_stop;
  logic                   is_ws;
  logic                   take;
  logic                   push_byte;
  logic [7:0]             dec_byte;
  logic [COUNT_WIDTH-1:0] total_byte;
  logic [31:0]            tot_ext;
  logic [31:0]            tot_byte_ext;
  logic [15:0]            shown_after;
  b64sd_pkg::out_item_t   byte_res;
  b64sd_pkg::out_item_t   done_res;

  assign ch   = in_data_i.char_in;
  assign last = in_data_i.end_of_text;
  assign val  = b64sd_pkg::sextet(ch);

  assign is_stop = (ch == b64sd_pkg::CH_PAD) || (ch == b64sd_pkg::CH_NUL);
  // Whitespace is only skipped when it falls between groups.
  assign is_ws   = (phase_q == b64sd_pkg::PH_FIRST) &&
                   ((ch == b64sd_pkg::CH_SPACE) || (ch == b64sd_pkg::CH_TAB) ||
                    (ch == b64sd_pkg::CH_CR)    || (ch == b64sd_pkg::CH_LF));
  assign take      = !stopped_q && !is_stop && !is_ws;
  assign push_byte = in_acc && take && (phase_q != b64sd_pkg::PH_FIRST);

  always_comb begin
    dec_byte = '0;
    pend_d   = pend_q;
    case (phase_q)
      b64sd_pkg::PH_FIRST: begin
        pend_d = val;
      end
      b64sd_pkg::PH_SECOND: begin
        dec_byte = {pend_q, val[5:4]};
        pend_d   = {2'b00, val[3:0]};
      end
      b64sd_pkg::PH_THIRD: begin
        dec_byte = {pend_q[3:0], val[5:2]};
        pend_d   = {4'b0000, val[1:0]};
      end
      b64sd_pkg::PH_FOURTH: begin
        dec_byte = {pend_q[1:0], val};
        pend_d   = '0;
      end
      default: begin
        dec_byte = '0;
        pend_d   = '0;
      end
    endcase
    if (!(in_acc && take)) begin
      pend_d = pend_q;
    end
  end

  // The counter saturates at its all-ones value.
  assign total_byte = (total_q != '1) ? total_q + 1'b1 : total_q;

  // The reported count saturates at 16 bits when the counter is wider.
  assign tot_byte_ext = 32'(total_byte);
  assign tot_ext      = 32'(push_byte ? total_byte : total_q);
  assign shown_after  = (|tot_ext[31:16]) ? 16'hFFFF : tot_ext[15:0];

  always_comb begin
    byte_res.byte_valid    = 1'b1;
    byte_res.data_byte     = dec_byte;
    byte_res.done_res      = 1'b0;
    byte_res.decoded_count = (|tot_byte_ext[31:16]) ? 16'hFFFF : tot_byte_ext[15:0];

    done_res.byte_valid    = 1'b0;
    done_res.data_byte     = '0;
    done_res.done_res      = 1'b1;
    done_res.decoded_count = shown_after;
  end

  always_comb begin
    phase_d   = phase_q;
    stopped_d = stopped_q;
    total_d   = total_q;
    if (in_acc) begin
      if (!stopped_q && is_stop) begin
        stopped_d = 1'b1;
      end
      if (take) begin
        phase_d = phase_q + 2'd1;
      end
      if (push_byte) begin
        total_d = total_byte;
      end
      // The last character re-arms the decoder for the next string.
      if (last) begin
        phase_d   = b64sd_pkg::PH_FIRST;
        stopped_d = 1'b0;
        total_d   = '0;
      end
    end
  end

  // The pending bits also return to zero when the last character re-arms.
  logic [5:0] pend_next;
  assign pend_next = (in_acc && last) ? 6'd0 : pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= b64sd_pkg::PH_FIRST;
      pend_q    <= '0;
      stopped_q <= 1'b0;
      total_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      pend_q    <= pend_next;
      stopped_q <= stopped_d;
      total_q   <= total_d;
    end
  end

  // -------------------------------------------------------------------------
  // Result queue. One character makes at most two results: a byte and the
  // final count, written in that order. The output side takes one result
  // per transfer. Input stalls while more than two results wait, so there
  // is always room for both results of the next character.
  // -------------------------------------------------------------------------
  b64sd_pkg::out_item_t res_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]     cnt_q, cnt_d;
  logic                 push_done;
  logic [QPtrW-1:0]     done_ptr;

  assign push_done = in_acc && last;
  assign done_ptr  = push_byte ? wr_ptr_q + 1'b1 : wr_ptr_q;

  assign in_stall_o  = (cnt_q > QCntW'(QDepth - 2));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_data_o  = res_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push_byte) + QPtrW'(push_done);
    rd_ptr_d = rd_ptr_q + QPtrW'(out_acc);
    cnt_d    = cnt_q + QCntW'(push_byte) + QCntW'(push_done) - QCntW'(out_acc);
  end

  always_ff @(posedge clk_i) begin
    if (push_byte) begin
      res_q[wr_ptr_q] <= byte_res;
    end
    if (push_done) begin
      res_q[done_ptr] <= done_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `B64SD_ASSERT(a_queue_bound, cnt_q <= QCntW'(QDepth), "result queue overflow")
  `B64SD_ASSERT_IMP(a_done_no_byte, out_valid_o && out_data_o.done_res, !out_data_o.byte_valid, "count result carries a byte")
  `B64SD_ASSERT_IMP(a_byte_counted, out_valid_o && out_data_o.byte_valid, out_data_o.decoded_count != '0, "byte result with zero count")
  `B64SD_ASSERT_NEXT(a_rearm, in_acc && in_data_i.end_of_text, phase_q == b64sd_pkg::PH_FIRST && !stopped_q && total_q == '0 && pend_q == '0, "decoder not re-armed after last character")
  `B64SD_ASSERT_IMP(a_stopped_quiet, stopped_q && in_acc, !push_byte, "byte decoded after stop")

endmodule
